// ===== sv/gve_pkg.sv =====
package gve_pkg;

   // Fixed geometry of one group
   localparam int unsigned LANES  = 4;
   localparam int unsigned VAL_W  = 32;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CODE_W = 2;
   localparam int unsigned LEN_W  = 5;
   localparam int unsigned LANE_W = 2;

   // Group length is the header byte plus one byte per value at minimum
   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(LANES + 1);

   typedef logic [VAL_W-1:0]  value_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [LANE_W-1:0] lane_type;

   // One analyzed group, as passed from the merge stage to the emitter
   typedef struct packed {
      value_type [LANES-1:0] vals;
      code_type  [LANES-1:0] codes;
      byte_type              header;
      len_type               total;
   } group_type;

   // Handshake between the merge stage and the emitter
   typedef struct packed {
      logic pending;
      logic load;
   } xfer_type;

endpackage

// ===== sv/gve_lane.sv =====
module gve_lane (
   input  gve_pkg::value_type value,
   output gve_pkg::code_type  code
);
   import gve_pkg::*;

   // Find the highest nonzero byte; a zero value still takes one byte
   always_comb begin
      if (|value[31:24]) begin
         code = 2'd3;
      end else if (|value[23:16]) begin
         code = 2'd2;
      end else if (|value[15:8]) begin
         code = 2'd1;
      end else begin
         code = 2'd0;
      end
   end

endmodule

// ===== sv/gve_merge.sv =====
module gve_merge (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  gve_pkg::value_type [3:0]       vals,
   input  gve_pkg::code_type  [3:0]       codes,
   input  logic                           load,
   output logic                           pending,
   output gve_pkg::group_type             group
);
   import gve_pkg::*;

   logic      valid_ff, valid_in;
   group_type group_ff, group_in;
   len_type   sum;

   // Combine the lane codes: header packs the first value's code into the top bits
   always_comb begin
      sum = MIN_LEN;
      for (int i = 0; i < LANES; i++) begin
         sum = sum + len_type'(codes[i]);
      end
      group_in.vals   = vals;
      group_in.codes  = codes;
      group_in.header = {codes[0], codes[1], codes[2], codes[3]};
      group_in.total  = sum;
   end

   // Hold one analyzed group until the emitter takes it
   assign valid_in = accept | (valid_ff & ~load);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         group_ff <= group_in;
      end
   end

   assign pending = valid_ff;
   assign group   = group_ff;

endmodule

// ===== sv/gve_emit.sv =====
module gve_emit (
   input  logic                clock,
   input  logic                reset,
   input  gve_pkg::group_type  group,
   input  logic                pending,
   output logic                load,
   output logic                strobe,
   output gve_pkg::byte_type   out_byte,
   output logic                last_byte,
   output gve_pkg::len_type    group_length,
   output gve_pkg::len_type    count
);
   import gve_pkg::*;

   logic      valid_ff, valid_in;
   logic      hdr_ff, hdr_in;
   lane_type  lane_ff, lane_in;
   code_type  byte_ff, byte_in;
   len_type   count_ff, count_in;
   group_type cur_ff;
   value_type cur_val;
   logic      at_last;

   assign at_last = valid_ff & (count_ff + 5'd1 == cur_ff.total);
   assign load    = pending & (~valid_ff | at_last);

   // Advance through header, then each lane's bytes low byte first
   always_comb begin
      valid_in = valid_ff;
      hdr_in   = hdr_ff;
      lane_in  = lane_ff;
      byte_in  = byte_ff;
      count_in = count_ff;
      if (load) begin
         valid_in = 1'b1;
         hdr_in   = 1'b1;
         lane_in  = '0;
         byte_in  = '0;
         count_in = '0;
      end else if (at_last) begin
         valid_in = 1'b0;
      end else if (valid_ff) begin
         count_in = count_ff + 5'd1;
         if (hdr_ff) begin
            hdr_in = 1'b0;
         end else if (byte_ff == cur_ff.codes[lane_ff]) begin
            lane_in = lane_ff + 2'd1;
            byte_in = '0;
         end else begin
            byte_in = byte_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hdr_ff   <= 1'b0;
         lane_ff  <= '0;
         byte_ff  <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         hdr_ff   <= hdr_in;
         lane_ff  <= lane_in;
         byte_ff  <= byte_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= group;
      end
   end

   // Select the byte on the output
   assign cur_val = cur_ff.vals[lane_ff];

   always_comb begin
      if (hdr_ff) begin
         out_byte = cur_ff.header;
      end else begin
         case (byte_ff)
            2'd0:    out_byte = cur_val[7:0];
            2'd1:    out_byte = cur_val[15:8];
            2'd2:    out_byte = cur_val[23:16];
            default: out_byte = cur_val[31:24];
         endcase
      end
   end

   assign strobe       = valid_ff;
   assign last_byte    = at_last;
   assign group_length = cur_ff.total;
   assign count        = count_ff;

endmodule

// ===== sv/group_varint_encode_4x32.sv =====
// Channel   Ports                                   Transfer
// -------   -------------------------------------   ------------------------
// request   start, busy, req_value_a..d            start high, busy low
// response  rsp_strobe, rsp_out_byte,              one byte per strobe cycle,
//           rsp_last_byte, rsp_group_length         receiver cannot stall
//
// A group of 5 to 17 bytes leaves one byte per cycle from the emitter, and the
// output port sets the sustained rate. One analyzed group waits in the merge
// register while the emitter drains the previous one, so groups leave back to
// back. When the block is idle an accepted group passes the merge register
// and the emitter register before its header byte is on the output. busy is
// high only while a group waits and the emitter is not on its final byte.
// Synchronous reset clears all control state.
module group_varint_encode_4x32 (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gve_pkg::value_type  req_value_a,
   input  gve_pkg::value_type  req_value_b,
   input  gve_pkg::value_type  req_value_c,
   input  gve_pkg::value_type  req_value_d,
   output logic                rsp_strobe,
   output gve_pkg::byte_type   rsp_out_byte,
   output logic                rsp_last_byte,
   output gve_pkg::len_type    rsp_group_length
);
   import gve_pkg::*;

   value_type [LANES-1:0] vals;
   code_type  [LANES-1:0] codes;
   group_type             group;
   xfer_type              xfer;
   logic                  accept;
   len_type               count;

   assign vals = {req_value_d, req_value_c, req_value_b, req_value_a};

   // One length finder per value
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      gve_lane u_lane (
         .value (vals[i]),
         .code  (codes[i])
      );
   end

   assign busy   = xfer.pending & ~xfer.load;
   assign accept = start & ~busy;

   gve_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .vals    (vals),
      .codes   (codes),
      .load    (xfer.load),
      .pending (xfer.pending),
      .group   (group)
   );

   gve_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .group        (group),
      .pending      (xfer.pending),
      .load         (xfer.load),
      .strobe       (rsp_strobe),
      .out_byte     (rsp_out_byte),
      .last_byte    (rsp_last_byte),
      .group_length (rsp_group_length),
      .count        (count)
   );

   // An accepted group starts or continues output once past the merge and emitter registers
   a_accept_emits: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("no output after accepted group");

   // A group is never cut short
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_byte |=> rsp_strobe && $stable(rsp_group_length))
      else $error("group output broken before final byte");

   // The final byte falls exactly at the group length
   a_last_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_byte |-> count + 5'd1 == rsp_group_length
         && rsp_group_length >= MIN_LEN)
      else $error("final byte at wrong position");

endmodule
